/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked immediate-style wrappers that every asserting file shares.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a condition at every clock edge outside reset.
`define ASSERT_NOW(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Checks that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(label, expr)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/madc_pkg.sv */
// ---------------------------------------------------------------------------
// madc_pkg
// Shared types and constants of the multiplexed ADC median limit checker.
// ---------------------------------------------------------------------------
package madc_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 3;
  localparam int REG_W    = 12;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_CELL_LOW    = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SENSOR_HIGH = 1'd1;

  localparam logic [REG_W-1:0] CELL_LOW_RESET    = 12'd3102;
  localparam logic [REG_W-1:0] SENSOR_HIGH_RESET = 12'd1861;

  localparam logic [CHAN_W-1:0] CELL_CH_FIRST = 3'd1;
  localparam logic [CHAN_W-1:0] CELL_CH_LAST  = 3'd4;
  localparam logic [CHAN_W-1:0] SENSOR_CH     = 3'd6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // One finished window: its two middle sorted values and its channel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mid_lo;
    logic [SAMPLE_W-1:0] mid_hi;
    logic [CHAN_W-1:0]   chan;
  } job_t;

  typedef struct packed {
    logic [REG_W-1:0] cell_low;
    logic [REG_W-1:0] sensor_high;
  } limits_t;

endpackage

/* sv/muxed_adc_median_limit_check.sv */
// ---------------------------------------------------------------------------
// muxed_adc_median_limit_check
// Median of each window of ADC samples per multiplexer channel, with limits.
// ---------------------------------------------------------------------------
// Samples of the selected channel enter on the sample beat, one per cycle when unstalled.
// Every SAMPLES samples form a window; its median, channel, limit flag and
// the following multiplexer select leave as one result beat.
// The input side takes a sample every cycle unless the queue is full; the
// insertion cells sort each sample into place in the cycle it arrives.
// A window's result is written into the queue and then into the output
// register before its result beat is valid.
// A two-window queue separates the sorter from the output register. When
// the receiver stalls, the output register holds its beat; the sorter keeps
// taking samples until the queue is full, then stalls the sample channel.
// Reset empties the queue, clears the sample count, selects channel 0 and
// loads the default limits. The user writes the limit registers through the
// cfg port only while no window is in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
module muxed_adc_median_limit_check #(
  parameter int SAMPLES = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [madc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [madc_pkg::REG_W-1:0]    cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [madc_pkg::SAMPLE_W-1:0] sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [madc_pkg::SAMPLE_W-1:0] median_value,
  output logic [madc_pkg::CHAN_W-1:0]   sampled_channel,
  output logic                          within_limits,
  output logic [madc_pkg::CHAN_W-1:0]   next_channel
);
  import madc_pkg::*;

  `include "assert_macros.svh"

  limits_t limits;
  job_t    job;
  job_t    q_data;
  logic    accept;
  logic    push;
  logic    q_full;
  logic    q_empty;
  logic    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.cell_low    <= CELL_LOW_RESET;
      limits.sensor_high <= SENSOR_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CELL_LOW:    limits.cell_low    <= cfg_data;
        REG_SENSOR_HIGH: limits.sensor_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample_stall = q_full;
  assign accept       = sample_valid && !q_full;

  madc_front #(.SAMPLES(SAMPLES)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (sample),
    .push   (push),
    .job    (job)
  );

  madc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  madc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_data          (q_data),
    .pop             (pop),
    .limits          (limits),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .median_value    (median_value),
    .sampled_channel (sampled_channel),
    .within_limits   (within_limits),
    .next_channel    (next_channel)
  );

  `ASSERT_NOW(a_no_push_when_full, !(push && q_full))
  `ASSERT_NOW(a_no_pop_when_empty, !(pop && q_empty))
  `ASSERT_NEXT(a_push_fills_queue, push, !q_empty)
  `ASSERT_NOW(a_next_follows, !result_valid || (next_channel == sampled_channel + 3'd1))

endmodule

/* sv/madc_front.sv */
// ---------------------------------------------------------------------------
// madc_front
// Insertion sorting cells that collect one window of samples per channel.
// ---------------------------------------------------------------------------
module madc_front #(
  parameter int SAMPLES = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [madc_pkg::SAMPLE_W-1:0] sample,
  output logic                      push,
  output madc_pkg::job_t            job
);
  import madc_pkg::*;

  localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int MID_LO = (SAMPLES - 1) / 2;
  localparam int MID_HI = SAMPLES / 2;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CHAN_W-1:0]   channel;
  logic                last;
  logic [SAMPLES-1:0]  gt;
  logic [SAMPLES-1:0]  take_prev;
  logic [SAMPLE_W-1:0] cells      [SAMPLES];
  logic [SAMPLE_W-1:0] prev_cell  [SAMPLES];
  logic [SAMPLE_W-1:0] cells_next [SAMPLES];

  assign last = (count == CNT_W'(SAMPLES - 1));
  assign count_next = last ? '0 : count + 1'b1;

  // The cells hold the samples seen so far in ascending order. Each cell
  // either keeps its value, takes its lower neighbor's or takes the new one.
  always_comb begin
    take_prev[0] = 1'b0;
    prev_cell[0] = sample;
    for (int i = 0; i < SAMPLES; i++) begin
      gt[i] = (i < int'(count)) && (cells[i] > sample);
    end
    for (int i = 1; i < SAMPLES; i++) begin
      take_prev[i] = gt[i-1];
      prev_cell[i] = cells[i-1];
    end
    for (int i = 0; i < SAMPLES; i++) begin
      cells_next[i] = cells[i];
      if ((i == int'(count)) || gt[i]) begin
        cells_next[i] = take_prev[i] ? prev_cell[i] : sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cells <= cells_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      channel <= '0;
    end else if (accept) begin
      count <= count_next;
      if (last) begin
        channel <= channel + 1'b1;
      end
    end
  end

  assign push       = accept && last;
  assign job.mid_lo = cells_next[MID_LO];
  assign job.mid_hi = cells_next[MID_HI];
  assign job.chan   = channel;

endmodule

/* sv/madc_queue.sv */
// ---------------------------------------------------------------------------
// madc_queue
// Two-entry queue of finished windows between the sorter and the checker.
// ---------------------------------------------------------------------------
module madc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  madc_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output madc_pkg::job_t pop_data,
  output logic           empty
);
  import madc_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* sv/madc_back.sv */
// ---------------------------------------------------------------------------
// madc_back
// Forms the median, checks the channel limit and holds the result beat.
// ---------------------------------------------------------------------------
module madc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  madc_pkg::job_t              q_data,
  output logic                        pop,
  input  madc_pkg::limits_t           limits,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [madc_pkg::SAMPLE_W-1:0] median_value,
  output logic [madc_pkg::CHAN_W-1:0]  sampled_channel,
  output logic                        within_limits,
  output logic [madc_pkg::CHAN_W-1:0]  next_channel
);
  import madc_pkg::*;

  logic [SAMPLE_W:0]   sum;
  logic [SAMPLE_W-1:0] median;
  logic                pass;

  // For an odd window both middle values are the same entry.
  assign sum    = {1'b0, q_data.mid_lo} + {1'b0, q_data.mid_hi};
  assign median = sum[SAMPLE_W:1];

  always_comb begin
    if ((q_data.chan >= CELL_CH_FIRST) && (q_data.chan <= CELL_CH_LAST)) begin
      pass = (median >= limits.cell_low);
    end else if (q_data.chan == SENSOR_CH) begin
      pass = (median <= limits.sensor_high);
    end else begin
      pass = 1'b1;
    end
  end

  assign pop = !q_empty && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      median_value    <= median;
      sampled_channel <= q_data.chan;
      within_limits   <= pass;
      next_channel    <= q_data.chan + 1'b1;
    end
  end

endmodule
